// ----- design/q27_audio_node_unit_macros.svh -----
// assertion macros for the q27 audio node unit
`ifndef Q27_AUDIO_NODE_UNIT_MACROS_SVH
`define Q27_AUDIO_NODE_UNIT_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define Q27AN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define Q27AN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/q27an_pkg.sv -----
// shared types, constants and arithmetic helpers for the q27 audio node unit
`default_nettype none
package q27an_pkg;

	localparam int NODE_SLOTS_DEFAULT = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SAW_STEP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PWM_STEP = CFG_IDX_W'(1);

	localparam logic [31:0] SAW_STEP_RESET = 32'd9842633;
	localparam logic [31:0] PWM_STEP_RESET = 32'd19685267;

	localparam logic signed [31:0] Q27_ONE = 32'sd134217728;
	localparam logic signed [31:0] Q27_NEG_ONE = -32'sd134217728;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	// ceil(2^30 / 3): exact division by three for values below 2^28
	localparam logic signed [31:0] DIV3_MAGIC = 32'sd357913942;
	localparam int DIV3_SHIFT = 30;

	typedef enum logic [2:0] {
		CMD_SAW    = 3'd0,
		CMD_PULSE  = 3'd1,
		CMD_SOFT   = 3'd2,
		CMD_SMOOTH = 3'd3,
		CMD_XFADE  = 3'd4,
		CMD_VCA    = 3'd5,
		CMD_STEREO = 3'd6
	} cmd_t;

	typedef struct packed {
		logic [2:0]         command;
		logic [3:0]         slot;
		logic signed [31:0] sample_a;
		logic signed [31:0] sample_b;
		logic signed [31:0] setting;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sample_out;
		logic signed [31:0] second_out;
	} out_item_t;

	typedef enum logic [2:0] {
		DP_IDLE,
		DP_ST1,
		DP_ST2,
		DP_ST3,
		DP_ST4,
		DP_ST5,
		DP_ST6,
		DP_ST7
	} dp_step_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ST1,
		S_ST2,
		S_ST3,
		S_ST4,
		S_ST5,
		S_ST6,
		S_ST7,
		S_PUSH
	} ctrl_state_t;

	typedef struct packed {
		logic     take;
		dp_step_t step;
		logic     push;
	} dp_ctrl_t;

	typedef struct packed {
		logic fin;
	} dp_stat_t;

	// floor(p / 2^27) saturated to signed 32 bits
	function automatic logic signed [31:0] q27_scale(input logic signed [63:0] p);
		logic [36:0] s;
		s = p[63:27];
		if (s[36:31] == {6{s[31]}})
			return s[31:0];
		else
			return s[36] ? S32_MIN : S32_MAX;
	endfunction

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] == v[31])
			return v[31:0];
		else
			return v[32] ? S32_MIN : S32_MAX;
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (v[33:31] == {3{v[31]}})
			return v[31:0];
		else
			return v[33] ? S32_MIN : S32_MAX;
	endfunction

	function automatic logic signed [31:0] clamp_q27(input logic signed [31:0] v);
		if (v > Q27_ONE)
			return Q27_ONE;
		else if (v < Q27_NEG_ONE)
			return Q27_NEG_ONE;
		else
			return v;
	endfunction

	function automatic logic signed [31:0] clamp_fade(input logic signed [31:0] v);
		if (v < 32'sd0)
			return 32'sd0;
		else if (v > Q27_ONE)
			return Q27_ONE;
		else
			return v;
	endfunction

endpackage
`default_nettype wire

// ----- design/q27_audio_node_unit.sv -----
// Q27 audio node unit: saw and pulse oscillators, smoother, soft clip, crossfade, VCA and
// stereo pass over one result register. An item is taken while the unit is idle and then
// steps until its operation is done: saw, pulse, stereo pass and unused codes end in ST1,
// smooth in ST2, VCA in ST3, crossfade in ST4 and soft clip in ST7, by the passes it needs
// through the single registered 32x32 multiplier. Slot state is cleared at reset by per-slot
// valid bits, so the unit takes items straight after reset with no clearing pass.
`default_nettype none
`include "q27_audio_node_unit_macros.svh"
module q27_audio_node_unit import q27an_pkg::*; #(
	parameter int NODE_SLOTS = NODE_SLOTS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire in_item_t              item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output out_item_t                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	dp_ctrl_t dp_ctrl;
	dp_stat_t dp_stat;

	q27an_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ctrl         (dp_ctrl),
		.stat         (dp_stat)
	);

	q27an_datapath #(
		.NODE_SLOTS (NODE_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.ctrl      (dp_ctrl),
		.stat      (dp_stat),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	`Q27AN_ASSERT_NEXT(a_take_busy, dp_ctrl.take, item_stall, "unit not busy after item transfer")
	`Q27AN_ASSERT_NEXT(a_push_valid, dp_ctrl.push, result_valid, "result not offered after push")
	`Q27AN_ASSERT_NOW(a_push_no_take, dp_ctrl.push, !dp_ctrl.take, "push and take in one cycle")
	`Q27AN_ASSERT_NOW(a_fin_in_step, dp_stat.fin, dp_ctrl.step != DP_IDLE, "finish outside a step")

endmodule
`default_nettype wire

// ----- design/q27an_ctrl.sv -----
// controller state machine: item transfer, step sequencing and result hand-off
`default_nettype none
module q27an_ctrl import q27an_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_stall,
	output logic          result_valid,
	input  wire logic     result_stall,
	output dp_ctrl_t      ctrl,
	input  wire dp_stat_t stat
);

	ctrl_state_t state_q, state_nxt;
	logic        result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.push)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctrl.take = 1'b0;
		ctrl.push = 1'b0;
		ctrl.step = DP_IDLE;
		case (state_q)
			S_IDLE: begin
				ctrl.take = item_valid;
				if (item_valid)
					state_nxt = S_ST1;
			end
			S_ST1: begin
				ctrl.step = DP_ST1;
				state_nxt = stat.fin ? S_PUSH : S_ST2;
			end
			S_ST2: begin
				ctrl.step = DP_ST2;
				state_nxt = stat.fin ? S_PUSH : S_ST3;
			end
			S_ST3: begin
				ctrl.step = DP_ST3;
				state_nxt = stat.fin ? S_PUSH : S_ST4;
			end
			S_ST4: begin
				ctrl.step = DP_ST4;
				state_nxt = stat.fin ? S_PUSH : S_ST5;
			end
			S_ST5: begin
				ctrl.step = DP_ST5;
				state_nxt = stat.fin ? S_PUSH : S_ST6;
			end
			S_ST6: begin
				ctrl.step = DP_ST6;
				state_nxt = stat.fin ? S_PUSH : S_ST7;
			end
			S_ST7: begin
				ctrl.step = DP_ST7;
				state_nxt = S_PUSH;
			end
			S_PUSH: begin
				ctrl.push = !result_valid_q || !result_stall;
				if (ctrl.push)
					state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign item_stall = (state_q != S_IDLE);
	assign result_valid = result_valid_q;

endmodule
`default_nettype wire

// ----- design/q27an_datapath.sv -----
// datapath: slot memory, step registers, shared multiplier and result register
`default_nettype none
module q27an_datapath import q27an_pkg::*; #(
	parameter int NODE_SLOTS = NODE_SLOTS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire in_item_t              item,
	input  wire dp_ctrl_t              ctrl,
	output dp_stat_t                   stat,
	output out_item_t                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SLOT_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
	localparam int SLOT_CODES = 16;

	logic [31:0]        mem [NODE_SLOTS];
	logic [NODE_SLOTS-1:0] valid_q;
	logic [31:0]        saw_step_q, pwm_step_q;

	logic [SLOT_W-1:0]  slot_map [SLOT_CODES];
	logic [SLOT_W-1:0]  idx_in;

	cmd_t               cmd_q;
	logic [SLOT_W-1:0]  idx_q;
	logic signed [31:0] a_q, b_q, set_q;
	logic [31:0]        rd_q;
	logic               rdv_q;
	logic signed [31:0] op_a_q, op_b_q;
	logic signed [63:0] mul_q;
	logic signed [31:0] acc_q;
	logic               neg_q;
	out_item_t          res_q;
	out_item_t          result_q;

	logic signed [31:0] word;
	logic signed [31:0] x_cl, f_cl, w_cl, qm, cu_abs, div3, soft_res;
	logic signed [32:0] diff, diff_adj;
	logic signed [31:0] diff16;
	logic signed [31:0] smooth_lvl, xf_sum;
	logic [31:0]        w_plus, thr;
	logic               wr_en;
	logic [31:0]        wr_data;

	// slot code wraps onto the configured number of slots
	for (genvar g = 0; g < SLOT_CODES; g++) begin : g_slot_map
		assign slot_map[g] = SLOT_W'(g % NODE_SLOTS);
	end
	assign idx_in = slot_map[item.slot];

	assign word = rdv_q ? $signed(rd_q) : 32'sd0;
	assign x_cl = clamp_q27(a_q);
	assign f_cl = clamp_fade(set_q);
	assign w_cl = clamp_q27(set_q);
	assign qm = q27_scale(mul_q);

	// pulse threshold wraps to zero at full width
	assign w_plus = w_cl + Q27_ONE;
	assign thr = {w_plus[27:0], 4'b0000};

	// truncating divide by sixteen
	assign diff = {set_q[31], set_q} - {word[31], word};
	assign diff_adj = diff[32] ? (diff + 33'sd15) : diff;
	assign diff16 = 32'(diff_adj >>> 4);
	assign smooth_lvl = sat34({{2{word[31]}}, word} + {{2{acc_q[31]}}, acc_q});

	assign xf_sum = sat33({acc_q[31], acc_q} + {qm[31], qm});

	assign cu_abs = qm[31] ? -qm : qm;
	assign div3 = 32'(mul_q >>> DIV3_SHIFT);
	assign soft_res = x_cl - (neg_q ? -div3 : div3);

	always_comb begin
		wr_en = 1'b0;
		wr_data = 32'd0;
		if (ctrl.step == DP_ST1 && cmd_q == CMD_SAW) begin
			wr_en = 1'b1;
			wr_data = word + saw_step_q;
		end else if (ctrl.step == DP_ST1 && cmd_q == CMD_PULSE) begin
			wr_en = 1'b1;
			wr_data = word + pwm_step_q;
		end else if (ctrl.step == DP_ST2 && cmd_q == CMD_SMOOTH) begin
			wr_en = 1'b1;
			wr_data = smooth_lvl;
		end
	end

	always_comb begin
		stat.fin = 1'b0;
		case (ctrl.step)
			DP_ST1: stat.fin = !(cmd_q inside {CMD_SOFT, CMD_SMOOTH, CMD_XFADE, CMD_VCA});
			DP_ST2: stat.fin = (cmd_q == CMD_SMOOTH);
			DP_ST3: stat.fin = (cmd_q == CMD_VCA);
			DP_ST4: stat.fin = (cmd_q == CMD_XFADE);
			DP_ST7: stat.fin = 1'b1;
			default: stat.fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			saw_step_q <= SAW_STEP_RESET;
			pwm_step_q <= PWM_STEP_RESET;
		end else begin
			if (wr_en)
				valid_q[idx_q] <= 1'b1;
			if (cfg_we) begin
				case (cfg_index)
					REG_SAW_STEP: saw_step_q <= cfg_data;
					REG_PWM_STEP: pwm_step_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[idx_q] <= wr_data;
		if (ctrl.take) begin
			rd_q <= mem[idx_in];
			rdv_q <= valid_q[idx_in];
		end
	end

	// shared multiplier
	always_ff @(posedge clk) begin
		mul_q <= op_a_q * op_b_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			cmd_q <= cmd_t'(item.command);
			idx_q <= idx_in;
			a_q <= item.sample_a;
			b_q <= item.sample_b;
			set_q <= item.setting;
		end
		if (ctrl.push)
			result_q <= res_q;
		case (ctrl.step)
			DP_ST1: begin
				case (cmd_q)
					CMD_SAW: res_q <= '{sample_out: word >>> 4, second_out: 32'sd0};
					CMD_PULSE: res_q <= '{sample_out: (word < thr) ? Q27_ONE : Q27_NEG_ONE,
						second_out: 32'sd0};
					CMD_SOFT: begin
						op_a_q <= x_cl;
						op_b_q <= x_cl;
					end
					CMD_SMOOTH: acc_q <= diff16;
					CMD_XFADE: begin
						op_a_q <= a_q;
						op_b_q <= Q27_ONE - f_cl;
					end
					CMD_VCA: begin
						op_a_q <= b_q;
						op_b_q <= a_q;
					end
					CMD_STEREO: res_q <= '{sample_out: a_q, second_out: b_q};
					default: res_q <= '{sample_out: 32'sd0, second_out: 32'sd0};
				endcase
			end
			DP_ST2: begin
				if (cmd_q == CMD_XFADE) begin
					op_a_q <= b_q;
					op_b_q <= f_cl;
				end
				if (cmd_q == CMD_SMOOTH)
					res_q <= '{sample_out: smooth_lvl, second_out: 32'sd0};
			end
			DP_ST3: begin
				if (cmd_q == CMD_SOFT) begin
					op_a_q <= qm;
					op_b_q <= x_cl;
				end
				if (cmd_q == CMD_XFADE)
					acc_q <= qm;
				if (cmd_q == CMD_VCA)
					res_q <= '{sample_out: qm, second_out: 32'sd0};
			end
			DP_ST4: begin
				if (cmd_q == CMD_XFADE)
					res_q <= '{sample_out: xf_sum, second_out: 32'sd0};
			end
			DP_ST5: begin
				op_a_q <= cu_abs;
				op_b_q <= DIV3_MAGIC;
				neg_q <= qm[31];
			end
			DP_ST7: res_q <= '{sample_out: soft_res, second_out: 32'sd0};
			default: ;
		endcase
	end

	assign result = result_q;

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// testbench for the q27 audio node unit: self-predicting stimulus, randomised stalls, result checks
`timescale 1ns / 1ps
module tb_top;
	import q27an_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SLOT_COUNT = NODE_SLOTS_DEFAULT;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
	localparam longint Q27 = longint'(Q27_ONE);

	typedef enum int {
		RX_NONE,
		RX_RANDOM,
		RX_PERIODIC,
		RX_BURSTY
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [31:0] saw_increment;
	logic [31:0] pulse_increment;
	logic [31:0] node_slot_words [SLOT_COUNT];
	out_item_t pending_outputs [$];

	int err_count = 0;
	int items_taken = 0;
	int results_seen = 0;
	int step_settings = 1;
	int idle_cycles = 0;
	int burst_left = 0;
	bit tx_gaps_on = 1'b1;
	rx_mode_t rx_mode = RX_RANDOM;
	int hold_request = 0;
	int hold_left = 0;
	int rx_phase = 0;
	int rx_run = 0;
	logic rx_hold = 1'b0;

	q27_audio_node_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic longint clip32(longint v);
		if (v > longint'(S32_MAX))
			return longint'(S32_MAX);
		if (v < longint'(S32_MIN))
			return longint'(S32_MIN);
		return v;
	endfunction

	function automatic longint clamp_range(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint q27_product(longint a, longint b);
		longint p;
		p = a * b;
		return clip32(p >>> 27);
	endfunction

	function automatic out_item_t node_op_result(in_item_t it);
		out_item_t res;
		longint a, b, set, phase_s, w, x, sq, cu, lvl, f, r1, r2;
		logic [31:0] phase, thr;
		a = longint'($signed(it.sample_a));
		b = longint'($signed(it.sample_b));
		set = longint'($signed(it.setting));
		phase = node_slot_words[it.slot];
		phase_s = longint'($signed(phase));
		r1 = 0;
		r2 = 0;
		case (it.command)
			CMD_SAW: begin
				r1 = phase_s >>> 4;
				node_slot_words[it.slot] = phase + saw_increment;
			end
			CMD_PULSE: begin
				w = clamp_range(set, -Q27, Q27);
				thr = 32'((w + Q27) * 16);
				r1 = (phase < thr) ? Q27 : -Q27;
				node_slot_words[it.slot] = phase + pulse_increment;
			end
			CMD_SOFT: begin
				x = clamp_range(a, -Q27, Q27);
				sq = q27_product(x, x);
				cu = q27_product(sq, x);
				r1 = clip32(x - cu / 3);
			end
			CMD_SMOOTH: begin
				lvl = clip32(phase_s + (set - phase_s) / 16);
				r1 = lvl;
				node_slot_words[it.slot] = lvl[31:0];
			end
			CMD_XFADE: begin
				f = clamp_range(set, 0, Q27);
				r1 = clip32(q27_product(a, Q27 - f) + q27_product(b, f));
			end
			CMD_VCA: begin
				r1 = q27_product(b, a);
			end
			CMD_STEREO: begin
				r1 = a;
				r2 = b;
			end
			default: begin
			end
		endcase
		res.sample_out = r1[31:0];
		res.second_out = r2[31:0];
		return res;
	endfunction

	function automatic in_item_t make_item(logic [2:0] cmd, logic [3:0] slot, logic [31:0] a,
			logic [31:0] b, logic [31:0] set);
		in_item_t it;
		it.command = cmd;
		it.slot = slot;
		it.sample_a = a;
		it.sample_b = b;
		it.setting = set;
		return it;
	endfunction

	function automatic logic [31:0] rand_sample();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			2, 3: v = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
			4: begin
				case ($urandom_range(0, 4))
					0: v = S32_MIN;
					1: v = S32_MAX;
					2: v = Q27_ONE;
					3: v = Q27_NEG_ONE;
					default: v = '0;
				endcase
			end
			5: begin
				v = Q27_ONE + $urandom_range(0, 4) - 2;
				if ($urandom_range(0, 1))
					v = -v;
			end
			6: v = $urandom_range(0, 512) - 256;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic in_item_t rand_node_item();
		logic [2:0] cmd;
		logic [3:0] slot;
		if ($urandom_range(0, 31) == 0)
			cmd = CMD_UNUSED;
		else
			cmd = 3'($urandom_range(0, 6));
		if ($urandom_range(0, 1))
			slot = 4'($urandom_range(0, 3));
		else
			slot = 4'($urandom_range(0, SLOT_COUNT - 1));
		return make_item(cmd, slot, rand_sample(), rand_sample(), rand_sample());
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at result %0d", what, got, want, results_seen);
		err_count++;
	endtask

	task automatic add_expected(out_item_t r);
		pending_outputs = {pending_outputs, r};
	endtask

	task automatic send_node_item(in_item_t it);
		int gap;
		if (tx_gaps_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 12);
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic wait_for_outputs();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SAW_STEP: saw_increment = val;
			REG_PWM_STEP: pulse_increment = val;
			default: begin
			end
		endcase
	endtask

	task automatic set_steps(logic [31:0] saw, logic [31:0] pulse);
		write_reg(REG_SAW_STEP, saw);
		write_reg(REG_PWM_STEP, pulse);
		step_settings++;
	endtask

	task automatic run_random(int n);
		repeat (n) send_node_item(rand_node_item());
	endtask

	task automatic test_stereo_extremes();
		send_node_item(make_item(CMD_STEREO, 4'd0, S32_MIN, S32_MAX, '0));
		send_node_item(make_item(CMD_STEREO, 4'd15, S32_MAX, S32_MIN, S32_MAX));
	endtask

	task automatic test_unused_code();
		send_node_item(make_item(CMD_UNUSED, 4'd3, S32_MAX, S32_MIN, S32_MIN));
	endtask

	task automatic test_oscillators();
		repeat (3) send_node_item(make_item(CMD_SAW, 4'd0, '0, '0, '0));
		send_node_item(make_item(CMD_SAW, 4'd15, S32_MAX, S32_MAX, S32_MAX));
		// full width wraps the threshold to zero
		send_node_item(make_item(CMD_PULSE, 4'd1, '0, '0, Q27_ONE));
		send_node_item(make_item(CMD_PULSE, 4'd1, '0, '0, S32_MAX));
		send_node_item(make_item(CMD_PULSE, 4'd1, '0, '0, S32_MIN));
		send_node_item(make_item(CMD_PULSE, 4'd1, '0, '0, '0));
	endtask

	task automatic test_soft_clip();
		send_node_item(make_item(CMD_SOFT, 4'd0, S32_MAX, '0, '0));
		send_node_item(make_item(CMD_SOFT, 4'd0, S32_MIN, '0, '0));
		send_node_item(make_item(CMD_SOFT, 4'd0, Q27_ONE, '0, '0));
		send_node_item(make_item(CMD_SOFT, 4'd0, Q27_NEG_ONE, '0, '0));
		send_node_item(make_item(CMD_SOFT, 4'd0, '0, '0, '0));
	endtask

	task automatic test_smooth();
		send_node_item(make_item(CMD_SMOOTH, 4'd2, '0, '0, S32_MAX));
		send_node_item(make_item(CMD_SMOOTH, 4'd2, '0, '0, S32_MAX));
		send_node_item(make_item(CMD_SMOOTH, 4'd2, '0, '0, S32_MIN));
	endtask

	task automatic test_xfade_vca();
		send_node_item(make_item(CMD_XFADE, 4'd0, S32_MAX, S32_MIN, 32'hFFFF_FFFF));
		send_node_item(make_item(CMD_XFADE, 4'd0, S32_MIN, S32_MAX, S32_MAX));
		send_node_item(make_item(CMD_XFADE, 4'd0, S32_MAX, S32_MAX, Q27_ONE >>> 1));
		send_node_item(make_item(CMD_VCA, 4'd0, S32_MIN, S32_MIN, '0));
		send_node_item(make_item(CMD_VCA, 4'd0, S32_MAX, S32_MIN, '0));
	endtask

	task automatic test_random_traffic();
		rx_mode = RX_RANDOM;
		run_random(250);
		wait_for_outputs();
	endtask

	task automatic test_zero_steps_no_idle();
		set_steps('0, '0);
		tx_gaps_on = 1'b0;
		rx_mode = RX_NONE;
		run_random(150);
		wait_for_outputs();
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_full_steps_spare_regs();
		set_steps(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		rx_mode = RX_PERIODIC;
		run_random(150);
		wait_for_outputs();
	endtask

	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		rx_mode = RX_RANDOM;
		hold_request = HOLD_OFF_CYCLES;
		run_random(60);
		wait_for_outputs();
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		set_steps($urandom, $urandom);
		rx_mode = RX_BURSTY;
		run_random(100);
		wait_for_outputs();
		run_random(100);
		wait_for_outputs();
	endtask

	task automatic test_default_steps();
		set_steps(SAW_STEP_RESET, PWM_STEP_RESET);
		rx_mode = RX_RANDOM;
		run_random(200);
		wait_for_outputs();
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (hold_request != 0) begin
			hold_left = hold_request - 1;
			hold_request = 0;
			result_stall <= 1'b1;
		end else begin
			rx_phase++;
			case (rx_mode)
				RX_NONE: result_stall <= 1'b0;
				RX_RANDOM: result_stall <= ($urandom_range(0, 99) < 35);
				RX_PERIODIC: result_stall <= ((rx_phase % 7) < 3);
				default: begin
					if (rx_run == 0) begin
						rx_run = $urandom_range(1, 20);
						rx_hold = ~rx_hold;
					end
					rx_run--;
					result_stall <= rx_hold;
				end
			endcase
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				add_expected(node_op_result(item));
				items_taken++;
			end
			if (result_valid && !result_stall) begin
				results_seen++;
				if (pending_outputs.size() == 0) begin
					report_mismatch("unexpected result", result.sample_out, '0);
				end else begin
					want = pending_outputs.pop_front();
					if (result.sample_out !== want.sample_out)
						report_mismatch("sample_out", result.sample_out, want.sample_out);
					if (result.second_out !== want.second_out)
						report_mismatch("second_out", result.second_out, want.second_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		saw_increment = SAW_STEP_RESET;
		pulse_increment = PWM_STEP_RESET;
		for (int i = 0; i < SLOT_COUNT; i++)
			node_slot_words[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stereo_extremes();
		test_unused_code();
		test_oscillators();
		test_soft_clip();
		test_smooth();
		test_xfade_vca();
		wait_for_outputs();
		test_random_traffic();
		test_zero_steps_no_idle();
		test_full_steps_spare_regs();
		test_backpressure();
		test_sender_pause();
		test_default_steps();

		if (pending_outputs.size() != 0)
			report_mismatch("results never arrived", pending_outputs.size(), '0);
		$display("checked %0d results from %0d items under %0d step settings", results_seen,
			items_taken, step_settings);
		$display("covered all operations, the unused code, stalls, a long hold-off and pauses");
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
